// File: src/assert_macros.svh
// Assertion macros used by the checker file of the lock manager.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, clocked on clk, off during rst.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, clocked on clk, off during rst.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/mtx_pkg.sv
// Field widths, command and status codes of the mutex lock manager.
`default_nettype none

package mtx_pkg;

  localparam int CMD_W    = 2;
  localparam int MID_W    = 8;
  localparam int TID_W    = 6;
  localparam int PRIO_W   = 6;
  localparam int STATUS_W = 3;
  localparam int HANDLE_W = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_CREATE = 2'd0,
    CMD_LOCK   = 2'd1,
    CMD_UNLOCK = 2'd2
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_NOMEM    = 3'd1,
    ST_INVALID  = 3'd2,
    ST_DEADLOCK = 3'd3,
    ST_NOTOWNER = 3'd4,
    ST_BLOCKED  = 3'd5
  } status_t;

endpackage

`default_nettype wire

// File: src/mutex_table_with_wait_queues.sv
// Top level of the mutex lock manager with per-mutex FIFO wait queues.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+---------------------------------------------
//   request | in        | in_valid / in_ready  | cmd, mutex_id, task_id, task_prio
//   result  | out       | out_valid/ out_ready | status, handle, caller_prio, wake_valid,
//           |           |                      | wake_task
//
// One request per cycle sustained while results are taken; a stalled result holds the flow.
// The request register feeds one pass of table logic into the result register; the
// task link and saved-priority memories are read as the request is taken.
// rst (synchronous) clears the created, locked, owner and queue-valid marks and the
// created count at once; in_ready stays low while rst is high, and no clearing pass
// follows, so requests are taken right after rst.
// A stalled result holds the request register; the block still takes a request when
// either register is empty or the result is being taken.
`default_nettype none

module mutex_table_with_wait_queues #(
  parameter int NUM_MUTEX = 32,
  parameter int NUM_TASKS = 64
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [mtx_pkg::CMD_W-1:0]     cmd,
  input  wire logic [mtx_pkg::MID_W-1:0]     mutex_id,
  input  wire logic [mtx_pkg::TID_W-1:0]     task_id,
  input  wire logic [mtx_pkg::PRIO_W-1:0]    task_prio,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [mtx_pkg::STATUS_W-1:0]       status,
  output logic [mtx_pkg::HANDLE_W-1:0]       handle,
  output logic [mtx_pkg::PRIO_W-1:0]         caller_prio,
  output logic                               wake_valid,
  output logic [mtx_pkg::TID_W-1:0]          wake_task
);

  localparam int MIDX_W = (NUM_MUTEX > 1) ? $clog2(NUM_MUTEX) : 1;
  localparam int TIDX_W = $clog2(NUM_TASKS);
  localparam int CNT_W  = $clog2(NUM_MUTEX + 1);
  // Wide enough to compare an 8-bit id against a bound of up to 256.
  localparam int CHK_W  = mtx_pkg::MID_W + 1;

  // ---------------------------------------------------------------- mutex table
  logic [NUM_MUTEX-1:0]           mutex_created;
  logic [NUM_MUTEX-1:0]           mutex_locked;
  logic [NUM_MUTEX-1:0]           queue_nonempty;
  logic [mtx_pkg::TID_W-1:0]      mutex_owner [NUM_MUTEX];
  logic [mtx_pkg::TID_W-1:0]      q_head      [NUM_MUTEX];
  logic [mtx_pkg::TID_W-1:0]      queue_tail  [NUM_MUTEX];
  logic [CNT_W-1:0]               created_count;

  // ---------------------------------------------------------------- task memories
  logic [mtx_pkg::TID_W-1:0]      task_next       [NUM_TASKS];
  logic [mtx_pkg::PRIO_W-1:0]     task_saved_prio [NUM_TASKS];

  // ---------------------------------------------------------------- request register
  logic                           s_valid;
  logic [mtx_pkg::CMD_W-1:0]      s_cmd;
  logic [mtx_pkg::MID_W-1:0]      s_mutex_id;
  logic [mtx_pkg::TID_W-1:0]      s_task_id;
  logic [mtx_pkg::PRIO_W-1:0]     s_task_prio;
  logic [mtx_pkg::TID_W-1:0]      s_head;   // queue head of the mutex, forwarded
  logic [mtx_pkg::TID_W-1:0]      s_link;   // link of that head waiter
  logic [mtx_pkg::PRIO_W-1:0]     s_sprio;  // saved priority of the caller

  // ---------------------------------------------------------------- handshake
  logic                           accept;
  logic                           s_fire;

  // ---------------------------------------------------------------- table pass
  logic                           s_m_ok;
  logic                           s_t_ok;
  logic [MIDX_W-1:0]              s_mi;
  logic [TIDX_W-1:0]              s_ti;
  logic                           req_ok;
  logic                           cur_locked;
  logic                           cur_nonempty;
  logic [mtx_pkg::TID_W-1:0]      cur_owner;
  logic [mtx_pkg::TID_W-1:0]      cur_tail;
  logic [TIDX_W-1:0]              tail_ti;
  logic                           ff_found;
  logic [MIDX_W-1:0]              ff_idx;

  mtx_pkg::status_t               res_status;
  logic [mtx_pkg::HANDLE_W-1:0]   res_handle;
  logic [mtx_pkg::PRIO_W-1:0]     res_prio;
  logic                           res_wake;
  logic [mtx_pkg::TID_W-1:0]      res_wake_task;

  logic                           create_we;
  logic                           lock_we;
  logic                           locked_next;
  logic [mtx_pkg::TID_W-1:0]      owner_next;
  logic                           ne_we;
  logic                           ne_next;
  logic                           head_we;
  logic [mtx_pkg::TID_W-1:0]      head_next;
  logic                           tail_we;
  logic                           link_we;
  logic                           prio_we;

  // ---------------------------------------------------------------- prefetch
  logic                           in_m_ok;
  logic [MIDX_W-1:0]              in_mi;
  logic [TIDX_W-1:0]              in_ti;
  logic [mtx_pkg::TID_W-1:0]      head_pref;
  logic [TIDX_W-1:0]              head_pref_ti;
  logic                           link_fwd;
  logic                           sprio_fwd;

  // Take a request when the request register is empty or moves on this edge.
  assign s_fire   = s_valid && (!out_valid || out_ready);
  assign in_ready = !rst && (!s_valid || !out_valid || out_ready);
  assign accept   = in_valid && in_ready;

  mtx_find_free #(
    .N     (NUM_MUTEX),
    .IDX_W (MIDX_W)
  ) u_find_free (
    .created (mutex_created),
    .found   (ff_found),
    .idx     (ff_idx)
  );

  // Decode the table entry addressed by the held request.
  always_comb begin
    s_m_ok       = CHK_W'(s_mutex_id) < CHK_W'(NUM_MUTEX);
    s_t_ok       = CHK_W'(s_task_id) < CHK_W'(NUM_TASKS);
    s_mi         = MIDX_W'(s_mutex_id);
    s_ti         = TIDX_W'(s_task_id);
    req_ok       = s_m_ok && s_t_ok && mutex_created[s_mi];
    cur_locked   = s_m_ok && mutex_locked[s_mi];
    cur_nonempty = s_m_ok && queue_nonempty[s_mi];
    cur_owner    = s_m_ok ? mutex_owner[s_mi] : '0;
    cur_tail     = s_m_ok ? queue_tail[s_mi] : '0;
    tail_ti      = TIDX_W'(cur_tail);
  end

  // One pass of the command over the addressed entry.
  always_comb begin
    res_status    = mtx_pkg::ST_INVALID;
    res_handle    = '0;
    res_prio      = s_task_prio;
    res_wake      = 1'b0;
    res_wake_task = '0;
    create_we     = 1'b0;
    lock_we       = 1'b0;
    locked_next   = 1'b0;
    owner_next    = '0;
    ne_we         = 1'b0;
    ne_next       = 1'b0;
    head_we       = 1'b0;
    head_next     = s_task_id;
    tail_we       = 1'b0;
    link_we       = 1'b0;
    prio_we       = 1'b0;

    unique case (mtx_pkg::cmd_t'(s_cmd))
      mtx_pkg::CMD_CREATE: begin
        // Hand out the lowest free handle while the table has room.
        if ((created_count < CNT_W'(NUM_MUTEX)) && ff_found) begin
          create_we  = 1'b1;
          res_handle = mtx_pkg::HANDLE_W'(ff_idx);
          res_status = mtx_pkg::ST_OK;
        end else begin
          res_status = mtx_pkg::ST_NOMEM;
        end
      end
      mtx_pkg::CMD_LOCK: begin
        if (!req_ok) begin
          res_status = mtx_pkg::ST_INVALID;
        end else if (cur_locked && (cur_owner == s_task_id)) begin
          res_status = mtx_pkg::ST_DEADLOCK;
        end else if (!cur_locked) begin
          // Acquire: save the caller's priority and run it at top priority.
          lock_we     = 1'b1;
          locked_next = 1'b1;
          owner_next  = s_task_id;
          prio_we     = 1'b1;
          res_prio    = '0;
          res_status  = mtx_pkg::ST_OK;
        end else begin
          // Held by another task: append the caller behind the tail.
          prio_we = 1'b1;
          if (cur_nonempty) begin
            link_we = 1'b1;
          end else begin
            head_we = 1'b1;
            ne_we   = 1'b1;
            ne_next = 1'b1;
          end
          tail_we    = 1'b1;
          res_status = mtx_pkg::ST_BLOCKED;
        end
      end
      mtx_pkg::CMD_UNLOCK: begin
        if (!req_ok) begin
          res_status = mtx_pkg::ST_INVALID;
        end else if (!cur_locked || (cur_owner != s_task_id)) begin
          res_status = mtx_pkg::ST_NOTOWNER;
        end else begin
          res_prio   = s_sprio;
          res_status = mtx_pkg::ST_OK;
          lock_we    = 1'b1;
          if (cur_nonempty) begin
            // Pass ownership to the head waiter and advance the queue.
            if (s_head == cur_tail) begin
              ne_we   = 1'b1;
              ne_next = 1'b0;
            end else begin
              head_we   = 1'b1;
              head_next = s_link;
            end
            locked_next   = 1'b1;
            owner_next    = s_head;
            res_wake      = 1'b1;
            res_wake_task = s_head;
          end else begin
            locked_next = 1'b0;
            owner_next  = '0;
          end
        end
      end
      default: begin
        res_status = mtx_pkg::ST_INVALID;
      end
    endcase
  end

  // Prefetch addresses for the incoming request, forwarding what the held
  // request writes on the same edge.
  always_comb begin
    in_m_ok      = CHK_W'(mutex_id) < CHK_W'(NUM_MUTEX);
    in_mi        = MIDX_W'(mutex_id);
    in_ti        = TIDX_W'(task_id);
    if (s_fire && head_we && s_m_ok && (s_mi == in_mi)) begin
      head_pref = head_next;
    end else if (in_m_ok) begin
      head_pref = q_head[in_mi];
    end else begin
      head_pref = '0;
    end
    head_pref_ti = TIDX_W'(head_pref);
    link_fwd     = s_fire && link_we && (tail_ti == head_pref_ti);
    sprio_fwd    = s_fire && prio_we && (s_ti == in_ti);
  end

  // Request register control.
  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (accept) begin
      s_valid <= 1'b1;
    end else if (s_fire) begin
      s_valid <= 1'b0;
    end
  end

  // Request payload and memory reads, taken together on accept.
  always_ff @(posedge clk) begin
    if (accept) begin
      s_cmd       <= cmd;
      s_mutex_id  <= mutex_id;
      s_task_id   <= task_id;
      s_task_prio <= task_prio;
      s_head      <= head_pref;
      if (link_fwd) begin
        s_link <= s_task_id;
      end else begin
        s_link <= task_next[head_pref_ti];
      end
      if (sprio_fwd) begin
        s_sprio <= s_task_prio;
      end else begin
        s_sprio <= task_saved_prio[in_ti];
      end
    end
  end

  // Task memory writes: link at the old tail, saved priority at the caller.
  always_ff @(posedge clk) begin
    if (s_fire && link_we) begin
      task_next[tail_ti] <= s_task_id;
    end
    if (s_fire && prio_we) begin
      task_saved_prio[s_ti] <= s_task_prio;
    end
  end

  // Mutex marks and owners, cleared by reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      mutex_created  <= '0;
      mutex_locked   <= '0;
      queue_nonempty <= '0;
      created_count  <= '0;
      for (int i = 0; i < NUM_MUTEX; i++) begin
        mutex_owner[i] <= '0;
      end
    end else if (s_fire) begin
      if (create_we) begin
        mutex_created[ff_idx] <= 1'b1;
        created_count         <= created_count + CNT_W'(1);
      end
      if (lock_we) begin
        mutex_locked[s_mi] <= locked_next;
        mutex_owner[s_mi]  <= owner_next;
      end
      if (ne_we) begin
        queue_nonempty[s_mi] <= ne_next;
      end
    end
  end

  // Queue pointers; meaningful only while the queue-valid mark is set.
  always_ff @(posedge clk) begin
    if (s_fire && head_we) begin
      q_head[s_mi] <= head_next;
    end
    if (s_fire && tail_we) begin
      queue_tail[s_mi] <= s_task_id;
    end
  end

  // Result register: hold until taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire) begin
      status      <= res_status;
      handle      <= res_handle;
      caller_prio <= res_prio;
      wake_valid  <= res_wake;
      wake_task   <= res_wake_task;
    end
  end

endmodule

`default_nettype wire

// File: src/mtx_find_free.sv
// Lowest-index search for a mutex handle that is not yet created.
`default_nettype none

module mtx_find_free #(
  parameter int N     = 32,
  parameter int IDX_W = 5
) (
  input  wire logic [N-1:0]     created,
  output logic                  found,
  output logic [IDX_W-1:0]      idx
);

  // Scan from the top so the lowest free entry wins.
  always_comb begin
    found = 1'b0;
    idx   = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (!created[i]) begin
        found = 1'b1;
        idx   = IDX_W'(i);
      end
    end
  end

endmodule

`default_nettype wire

// File: src/mtx_checker.sv
// Port-level checks of the mutex lock manager, bound to its top level.
`default_nettype none
`include "assert_macros.svh"

module mtx_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          in_ready,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic [mtx_pkg::STATUS_W-1:0]  status,
  input wire logic [mtx_pkg::HANDLE_W-1:0]  handle,
  input wire logic [mtx_pkg::PRIO_W-1:0]    caller_prio,
  input wire logic                          wake_valid,
  input wire logic [mtx_pkg::TID_W-1:0]     wake_task
);

  // A stalled result holds its value.
  `ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(status) && $stable(handle) && $stable(caller_prio) && $stable(wake_valid) && $stable(wake_task), "result changed while stalled")

  // An empty result side never blocks a request.
  `ASSERT_IMPL(a_ready_when_empty, !out_valid, in_ready, "request blocked with empty result register")

  // A handoff only comes from a successful unlock.
  `ASSERT_IMPL(a_wake_ok, out_valid && wake_valid, status == mtx_pkg::ST_OK, "wake reported without ok status")

  // A nonzero handle or waiter only travels with its own success case.
  `ASSERT_IMPL(a_fields_quiet, out_valid && ((handle != '0) || (wake_task != '0)), (status == mtx_pkg::ST_OK) && ((wake_task == '0) || wake_valid), "stray handle or waiter on result")

endmodule

bind mutex_table_with_wait_queues mtx_checker u_mtx_checker (.*);

`default_nettype wire
